@@ rtl/gsm_pkg.sv @@
// Shared constants and types for the glob segment matcher.
package gsm_pkg;

    localparam int PATTERN_MAX_DEF = 32;

    localparam int MODE_W = 2;
    localparam int CHAR_W = 8;
    localparam int CLASS_W = 2;

    localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd0;
    localparam logic [MODE_W-1:0] MODE_NAME    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_END     = 2'd2;

    localparam logic [CHAR_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
    localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
    localparam logic [CHAR_W-1:0] CH_SLASH = 8'h2F;
    localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;

    // Name prefix classes used to spot the "." and ".." entries.
    localparam logic [CLASS_W-1:0] CLS_EMPTY  = 2'd0;
    localparam logic [CLASS_W-1:0] CLS_DOT    = 2'd1;
    localparam logic [CLASS_W-1:0] CLS_DOTDOT = 2'd2;
    localparam logic [CLASS_W-1:0] CLS_OTHER  = 2'd3;

    typedef struct packed {
        logic                load;
        logic                step;
        logic                clear;
        logic [CHAR_W-1:0]   char_code;
    } cell_ctrl_t;

endpackage

@@ rtl/gsm_in_if.sv @@
// Input channel: pattern characters, name characters and end-of-name beats.
interface gsm_in_if;
    logic                         valid;
    logic                         ready;
    logic [gsm_pkg::MODE_W-1:0]   mode;
    logic [gsm_pkg::CHAR_W-1:0]   char_code;
    logic                         restart;

    modport source (output valid, output mode, output char_code, output restart, input ready);
    modport sink (input valid, input mode, input char_code, input restart, output ready);
endinterface

@@ rtl/gsm_out_if.sv @@
// Output channel: one match result per name.
interface gsm_out_if;
    logic valid;
    logic ready;
    logic matched;
    logic dot_entry;
    logic pattern_overflow;

    modport source (output valid, output matched, output dot_entry, output pattern_overflow,
                    input ready);
    modport sink (input valid, input matched, input dot_entry, input pattern_overflow,
                  output ready);
endinterface

@@ rtl/glob_segment_matcher.sv @@
// Top level of the glob segment matcher: control, cell row and result register.
// Latency: the result of an end-of-name beat is valid in the cycle after it is taken.
// Throughput: one beat per cycle while the output is not stalled; each name character
// updates the whole cell row through the star-closure prefix network.
// Reset: pattern empty and open, no overflow, only position zero active,
// reject_dot_names set, output register empty.
module glob_segment_matcher #(
    parameter int PATTERN_MAX = gsm_pkg::PATTERN_MAX_DEF
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_wr_en,
    input  logic       cfg_wr_data,
    gsm_in_if.sink     in_ch,
    gsm_out_if.source  out_ch
);

    localparam int CW = $clog2(PATTERN_MAX + 1);

    logic                           reject_reg;
    logic [CW-1:0]                  count_reg;
    logic [CW-1:0]                  count_next;
    logic                           closed_reg;
    logic                           closed_next;
    logic                           ovf_reg;
    logic                           ovf_next;
    logic                           act0_reg;
    logic                           act0_next;
    logic [gsm_pkg::CLASS_W-1:0]    class_reg;
    logic [gsm_pkg::CLASS_W-1:0]    class_next;
    logic                           out_valid_reg;
    logic                           matched_reg;
    logic                           dot_reg;
    logic                           out_ovf_reg;

    logic                           accept;
    logic                           is_pattern;
    logic                           is_name;
    logic                           is_end;
    logic                           end_char;
    logic [CW-1:0]                  count_eff;
    logic                           closed_eff;
    logic                           ovf_eff;
    logic                           dot_now;
    logic                           hit_now;
    gsm_pkg::cell_ctrl_t            ctrl;

    logic [PATTERN_MAX-1:0]         star_vec;
    logic [PATTERN_MAX-1:0]         keep_vec;
    logic [PATTERN_MAX-1:0]         act_hi;
    logic [PATTERN_MAX-1:0]         keep_nb;
    logic [PATTERN_MAX:0]           raw_vec;
    logic [PATTERN_MAX:0]           closed_vec;

    assign in_ch.ready = !out_valid_reg || out_ch.ready;
    assign accept = in_ch.valid && in_ch.ready;
    assign is_pattern = accept && (in_ch.mode == gsm_pkg::MODE_PATTERN);
    assign is_name    = accept && (in_ch.mode == gsm_pkg::MODE_NAME);
    assign is_end     = accept && (in_ch.mode == gsm_pkg::MODE_END);
    assign end_char   = (in_ch.char_code == gsm_pkg::CH_NUL) ||
                        (in_ch.char_code == gsm_pkg::CH_SLASH);

    // Restart clears the pattern before the character is looked at.
    assign count_eff  = in_ch.restart ? '0 : count_reg;
    assign closed_eff = in_ch.restart ? 1'b0 : closed_reg;
    assign ovf_eff    = in_ch.restart ? 1'b0 : ovf_reg;

    assign ctrl.load      = is_pattern && !closed_eff && !end_char &&
                            (count_eff < CW'(PATTERN_MAX));
    assign ctrl.step      = is_name;
    assign ctrl.clear     = is_pattern || is_end;
    assign ctrl.char_code = in_ch.char_code;

    always_comb
    begin
        count_next  = count_reg;
        closed_next = closed_reg;
        ovf_next    = ovf_reg;
        if (is_pattern)
        begin
            count_next  = count_eff;
            closed_next = closed_eff;
            ovf_next    = ovf_eff;
            if (!closed_eff)
            begin
                priority if (end_char)
                    closed_next = 1'b1;
                else if (ctrl.load)
                    count_next = count_eff + CW'(1);
                else
                    ovf_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        priority if (ctrl.clear)
            act0_next = 1'b1;
        else if (ctrl.step)
            act0_next = keep_vec[0];
        else
            act0_next = act0_reg;
    end

    always_comb
    begin
        priority if (ctrl.clear)
            class_next = gsm_pkg::CLS_EMPTY;
        else if (ctrl.step)
        begin
            if ((in_ch.char_code == gsm_pkg::CH_DOT) &&
                ((class_reg == gsm_pkg::CLS_EMPTY) || (class_reg == gsm_pkg::CLS_DOT)))
                class_next = class_reg + gsm_pkg::CLASS_W'(1);
            else
                class_next = gsm_pkg::CLS_OTHER;
        end
        else
            class_next = class_reg;
    end

    assign raw_vec = {act_hi, act0_reg};
    assign keep_nb = {1'b0, keep_vec[PATTERN_MAX-1:1]};

    gsm_closure #(
        .PATTERN_MAX(PATTERN_MAX)
    ) u_closure (
        .raw    (raw_vec),
        .star   (star_vec),
        .closed (closed_vec)
    );

    for (genvar j = 0; j < PATTERN_MAX; j++)
    begin : g_cell
        gsm_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .wr_sel     (count_eff == CW'(j)),
            .in_use     (count_reg > CW'(j)),
            .closed_bit (closed_vec[j]),
            .keep_in    (keep_nb[j]),
            .star       (star_vec[j]),
            .keep       (keep_vec[j]),
            .act        (act_hi[j])
        );
    end

    assign dot_now = (class_reg == gsm_pkg::CLS_DOT) || (class_reg == gsm_pkg::CLS_DOTDOT);
    assign hit_now = closed_vec[count_reg] && !ovf_reg && !(dot_now && reject_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reject_reg    <= 1'b1;
            count_reg     <= '0;
            closed_reg    <= 1'b0;
            ovf_reg       <= 1'b0;
            act0_reg      <= 1'b1;
            class_reg     <= gsm_pkg::CLS_EMPTY;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                reject_reg <= cfg_wr_data;
            end
            count_reg  <= count_next;
            closed_reg <= closed_next;
            ovf_reg    <= ovf_next;
            act0_reg   <= act0_next;
            class_reg  <= class_next;
            if (is_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (is_end)
        begin
            matched_reg <= hit_now;
            dot_reg     <= dot_now;
            out_ovf_reg <= ovf_reg;
        end
    end

    assign out_ch.valid            = out_valid_reg;
    assign out_ch.matched          = matched_reg;
    assign out_ch.dot_entry        = dot_reg;
    assign out_ch.pattern_overflow = out_ovf_reg;

endmodule

@@ rtl/gsm_closure.sv @@
// Star closure of the active position set as a parallel prefix network.
module gsm_closure #(
    parameter int PATTERN_MAX = gsm_pkg::PATTERN_MAX_DEF
) (
    input  logic [PATTERN_MAX:0]   raw,
    input  logic [PATTERN_MAX-1:0] star,
    output logic [PATTERN_MAX:0]   closed
);

    localparam int NPOS = PATTERN_MAX + 1;
    localparam int LEVELS = $clog2(NPOS);

    logic [NPOS-1:0] gen_lvl [LEVELS+1];
    logic [NPOS-1:0] prop_lvl [LEVELS+1];

    // Position j is reached from j-1 when pattern character j-1 is a star,
    // so the closure is a carry-style prefix over the star run.
    always_comb
    begin
        gen_lvl[0] = raw;
        prop_lvl[0] = {star, 1'b0};
        for (int l = 0; l < LEVELS; l++)
        begin
            for (int j = 0; j < NPOS; j++)
            begin
                if (j >= (1 << l))
                begin
                    gen_lvl[l+1][j]  = gen_lvl[l][j] | (prop_lvl[l][j] & gen_lvl[l][j-(1<<l)]);
                    prop_lvl[l+1][j] = prop_lvl[l][j] & prop_lvl[l][j-(1<<l)];
                end
                else
                begin
                    gen_lvl[l+1][j]  = gen_lvl[l][j];
                    prop_lvl[l+1][j] = prop_lvl[l][j];
                end
            end
        end
        closed = gen_lvl[LEVELS];
    end

endmodule

@@ rtl/gsm_cell.sv @@
// One pattern position: its character and the active bit of the next position.
module gsm_cell (
    input  logic                 clk,
    input  logic                 rst_n,
    input  gsm_pkg::cell_ctrl_t  ctrl,
    input  logic                 wr_sel,
    input  logic                 in_use,
    input  logic                 closed_bit,
    input  logic                 keep_in,
    output logic                 star,
    output logic                 keep,
    output logic                 act
);

    logic [gsm_pkg::CHAR_W-1:0] pat_reg;
    logic                       act_reg;
    logic                       act_next;
    logic                       nonzero;
    logic                       fwd;

    assign nonzero = (ctrl.char_code != gsm_pkg::CH_NUL);
    assign star = in_use && (pat_reg == gsm_pkg::CH_STAR);
    // A star keeps its own position alive; any other character moves on by one.
    assign keep = closed_bit && star && nonzero;
    assign fwd  = closed_bit && in_use && nonzero && !star &&
                  ((pat_reg == gsm_pkg::CH_QUEST) || (pat_reg == ctrl.char_code));
    assign act = act_reg;

    always_comb
    begin
        priority if (ctrl.clear)
            act_next = 1'b0;
        else if (ctrl.step)
            act_next = fwd | keep_in;
        else
            act_next = act_reg;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load && wr_sel)
        begin
            pat_reg <= ctrl.char_code;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_reg <= 1'b0;
        end
        else
        begin
            act_reg <= act_next;
        end
    end

endmodule
